[rtl/iirtdf2_pkg.sv]
// Package for the transposed direct-form II IIR filter: widths, register
// indexes, microcode field codes, the control store and the saturation helpers.
// No dependencies.
package iirtdf2_pkg;

   // Fixed field and datapath widths
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int DELAY_W   = 48;          // Q28.20 delays and y
   localparam int FRAC_W    = 20;
   localparam int ROUND_BIT = FRAC_W - 1;
   localparam int LO_W      = 24;          // low slice of y fed to the multiplier
   localparam int MUL_A_W   = LO_W + 1;    // signed multiplier operand A
   localparam int PROD_W    = MUL_A_W + COEF_W;
   localparam int ACC_W     = 54;          // holds d + x*b - a*y before saturation
   localparam int HI_SH     = LO_W - FRAC_W;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 3;

   localparam logic [COEF_W-1:0] COEF_ONE = 24'h100000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_B3 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_A3 = 3'd6;

   // Multiplier operand A select
   localparam logic [1:0] MA_XIN = 2'd0;   // sample straight from the input channel
   localparam logic [1:0] MA_X   = 2'd1;   // latched sample
   localparam logic [1:0] MA_YLO = 2'd2;   // y[23:0], zero extended
   localparam logic [1:0] MA_YHI = 2'd3;   // y[47:24], signed

   // Coefficient select
   localparam logic [1:0] CS_B0    = 2'd0;
   localparam logic [1:0] CS_BT    = 2'd1;
   localparam logic [1:0] CS_AT    = 2'd2;
   localparam logic [1:0] CS_BNEXT = 2'd3;

   // Accumulator operations
   localparam logic [2:0] AO_NONE = 3'd0;
   localparam logic [2:0] AO_Y    = 3'd1;  // y = sat(x*b0 + d0)
   localparam logic [2:0] AO_LOAD = 3'd2;  // acc = x*b[t] + d[t]
   localparam logic [2:0] AO_RND  = 3'd3;  // acc -= round(lo product)
   localparam logic [2:0] AO_WB   = 3'd4;  // d[t-1] = sat(acc - hi product << 4)

   // Sequencing
   localparam logic [1:0] SQ_NEXT    = 2'd0;
   localparam logic [1:0] SQ_WAIT_IN = 2'd1;
   localparam logic [1:0] SQ_LOOP    = 2'd2;

   // Tap counter operations
   localparam logic [1:0] TO_HOLD = 2'd0;
   localparam logic [1:0] TO_SET1 = 2'd1;
   localparam logic [1:0] TO_INC  = 2'd2;

   // Step addresses
   localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STEP_W-1:0] ST_Y    = 3'd1;
   localparam logic [STEP_W-1:0] ST_LO   = 3'd2;
   localparam logic [STEP_W-1:0] ST_HI   = 3'd3;
   localparam logic [STEP_W-1:0] ST_WB   = 3'd4;

   typedef struct packed {
      logic [1:0]        mul_a;
      logic [1:0]        coef;
      logic [2:0]        acc_op;
      logic              emit;
      logic [1:0]        seq;
      logic [STEP_W-1:0] target;
      logic [1:0]        tap_op;
   } ucode_type;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{mul_a: MA_XIN, coef: CS_B0, acc_op: AO_NONE, emit: 1'b0,
            seq: SQ_WAIT_IN, target: ST_IDLE, tap_op: TO_SET1};
      case (step)
         ST_IDLE: begin
            w = '{mul_a: MA_XIN, coef: CS_B0, acc_op: AO_NONE, emit: 1'b0,
                  seq: SQ_WAIT_IN, target: ST_IDLE, tap_op: TO_SET1};
         end
         ST_Y: begin
            w = '{mul_a: MA_X, coef: CS_BT, acc_op: AO_Y, emit: 1'b1,
                  seq: SQ_NEXT, target: ST_IDLE, tap_op: TO_HOLD};
         end
         ST_LO: begin
            w = '{mul_a: MA_YLO, coef: CS_AT, acc_op: AO_LOAD, emit: 1'b0,
                  seq: SQ_NEXT, target: ST_IDLE, tap_op: TO_HOLD};
         end
         ST_HI: begin
            w = '{mul_a: MA_YHI, coef: CS_AT, acc_op: AO_RND, emit: 1'b0,
                  seq: SQ_NEXT, target: ST_IDLE, tap_op: TO_HOLD};
         end
         ST_WB: begin
            w = '{mul_a: MA_X, coef: CS_BNEXT, acc_op: AO_WB, emit: 1'b0,
                  seq: SQ_LOOP, target: ST_LO, tap_op: TO_INC};
         end
         default: begin
            w = '{mul_a: MA_XIN, coef: CS_B0, acc_op: AO_NONE, emit: 1'b0,
                  seq: SQ_WAIT_IN, target: ST_IDLE, tap_op: TO_SET1};
         end
      endcase
      return w;
   endfunction

   // Saturate an accumulator value to the signed 48-bit delay range
   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DELAY_W:0] upper;
      logic signed [DELAY_W-1:0] res;
      upper = v[ACC_W-1:DELAY_W-1];
      if ((&upper) || !(|upper)) begin
         res = v[DELAY_W-1:0];
      end else if (v[ACC_W-1]) begin
         res = {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DELAY_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

[rtl/iirtdf2_req_if.sv]
// Input channel of the IIR filter: valid/ready handshake and one sample per item.
// Depends on iirtdf2_pkg.
interface iirtdf2_req_if;
   import iirtdf2_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/iirtdf2_rsp_if.sv]
// Result channel of the IIR filter: valid/ready handshake, filtered sample and clip flag.
// Depends on iirtdf2_pkg.
interface iirtdf2_rsp_if;
   import iirtdf2_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[rtl/iir_transposed_df2_filter_top.sv]
// Transposed direct-form II IIR filter, order TAPS (1..3), microcoded over one multiplier.
// Input: a new item is accepted only in the idle step with the skid entry empty; each tap costs three passes
// through the single shared 25x24 multiplier, stepped by the five-word control store.
// Result path: the x*b0 product, then y, then the output register (the skid entry if the output stalls).
// Reset: coefficients return to b0 = 1.0 and all others zero, delays clear, output empties.
// Depends on iirtdf2_pkg, iirtdf2_req_if, iirtdf2_rsp_if.
module iir_transposed_df2_filter_top #(
   parameter int TAPS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   iirtdf2_req_if.sink                          req_chan,
   iirtdf2_rsp_if.source                        rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [iirtdf2_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [iirtdf2_pkg::COEF_W-1:0]       csr_wdata
);
   import iirtdf2_pkg::*;

   localparam int ORDER    = (TAPS < 1) ? 1 : ((TAPS > 3) ? 3 : TAPS);
   localparam int NUM_COEF = (ORDER >= 3) ? 7 : 5;
   localparam int TAP_W    = $clog2(ORDER + 2);
   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER);

   // Coefficient index for b[tap] and a[tap]
   function automatic logic [CSR_IDX_W-1:0] b_index(input logic [TAP_W-1:0] tap);
      logic [CSR_IDX_W-1:0] idx;
      if (tap == TAP_W'(1))      idx = REG_B1;
      else if (tap == TAP_W'(2)) idx = REG_B2;
      else if (tap == TAP_W'(3)) idx = REG_B3;
      else                       idx = REG_B0;
      return idx;
   endfunction

   function automatic logic [CSR_IDX_W-1:0] a_index(input logic [TAP_W-1:0] tap);
      logic [CSR_IDX_W-1:0] idx;
      if (tap == TAP_W'(2))      idx = REG_A2;
      else if (tap == TAP_W'(3)) idx = REG_A3;
      else                       idx = REG_A1;
      return idx;
   endfunction

   // Sequencer state
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TAP_W-1:0]  t_ff, t_in, t_plus;
   ucode_type         uc;
   logic              accept;

   // Datapath registers
   logic signed [COEF_W-1:0]   coef_ff [NUM_COEF];
   logic signed [DELAY_W-1:0]  delay_ff [ORDER];
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [DELAY_W-1:0]  y_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       emit_ff;

   // Output register and one skid entry
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_clip_ff, rsp_clip_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic signed [SAMPLE_W-1:0] pend_sample_ff, pend_sample_in;
   logic                       pend_clip_ff, pend_clip_in;

   logic [CSR_IDX_W-1:0]       coef_idx;
   logic signed [COEF_W-1:0]   coef_rd;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [DELAY_W-1:0]  dnext;
   logic signed [ACC_W-1:0]    y_sum, load_sum;
   logic signed [PROD_W:0]     lo_rnd;
   logic signed [PROD_W-FRAC_W:0] lo_q;
   logic signed [PROD_W+HI_SH-1:0] hi_sh;
   logic signed [DELAY_W-1:0]  wb_val;
   logic signed [DELAY_W:0]    y_rnd;
   logic signed [DELAY_W-FRAC_W:0] r_q;
   logic [DELAY_W-FRAC_W-SAMPLE_W+1:0] r_upper;
   logic signed [SAMPLE_W-1:0] res_sample;
   logic                       res_clip;
   logic                       rsp_open;

   // Handshake
   assign req_chan.ready = (step_ff == ST_IDLE) && !pend_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign uc             = ucode_rom(step_ff);
   assign t_plus         = t_ff + TAP_W'(1);

   // Next step and tap counter
   always_comb begin
      case (uc.seq)
         SQ_NEXT:    step_in = step_ff + STEP_W'(1);
         SQ_WAIT_IN: step_in = accept ? step_ff + STEP_W'(1) : step_ff;
         SQ_LOOP:    step_in = (t_ff < LAST_TAP) ? uc.target : ST_IDLE;
         default:    step_in = ST_IDLE;
      endcase
      case (uc.tap_op)
         TO_SET1: t_in = TAP_W'(1);
         TO_INC:  t_in = t_plus;
         default: t_in = t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         t_ff    <= TAP_W'(1);
      end else begin
         step_ff <= step_in;
         t_ff    <= t_in;
      end
   end

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= (i == 0) ? COEF_ONE : '0;
         end
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_COEF))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Coefficient read for the current step
   always_comb begin
      case (uc.coef)
         CS_B0:    coef_idx = REG_B0;
         CS_BT:    coef_idx = b_index(t_ff);
         CS_AT:    coef_idx = a_index(t_ff);
         CS_BNEXT: coef_idx = b_index(t_plus);
         default:  coef_idx = REG_B0;
      endcase
      coef_rd = (coef_idx < CSR_IDX_W'(NUM_COEF)) ? coef_ff[coef_idx] : '0;
   end

   // Shared multiplier, registered product
   always_comb begin
      case (uc.mul_a)
         MA_XIN:  mul_a = MUL_A_W'(req_chan.sample_in);
         MA_X:    mul_a = MUL_A_W'(x_ff);
         MA_YLO:  mul_a = {1'b0, y_ff[LO_W-1:0]};
         MA_YHI:  mul_a = {y_ff[DELAY_W-1], y_ff[DELAY_W-1:LO_W]};
         default: mul_a = '0;
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(coef_rd);
   end

   // Delay that feeds the current tap; the last tap gets none
   always_comb begin
      dnext = '0;
      for (int j = 1; j < ORDER; j++) begin
         if (t_ff == TAP_W'(j)) dnext = delay_ff[j];
      end
   end

   // Accumulator terms
   assign y_sum    = ACC_W'(prod_ff) + ACC_W'(delay_ff[0]);
   assign load_sum = ACC_W'(prod_ff) + ACC_W'(dnext);
   assign lo_rnd   = (PROD_W+1)'(prod_ff) + ((PROD_W+1)'(1) << ROUND_BIT);
   assign lo_q     = lo_rnd[PROD_W:FRAC_W];
   assign hi_sh    = {prod_ff, {HI_SH{1'b0}}};
   assign wb_val   = sat_delay(acc_ff - ACC_W'(hi_sh));

   always_comb begin
      case (uc.acc_op)
         AO_LOAD: acc_in = load_sum;
         AO_RND:  acc_in = acc_ff - ACC_W'(lo_q);
         default: acc_in = acc_ff;
      endcase
   end

   // Datapath payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (accept) x_ff <= req_chan.sample_in;
      if (uc.acc_op == AO_Y) y_ff <= sat_delay(y_sum);
   end

   // Delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ORDER; j++) delay_ff[j] <= '0;
      end else if (uc.acc_op == AO_WB) begin
         for (int j = 0; j < ORDER; j++) begin
            if (t_ff == TAP_W'(j + 1)) delay_ff[j] <= wb_val;
         end
      end
   end

   // Result: round half up, saturate to 16 bits
   always_comb begin
      y_rnd   = (DELAY_W+1)'(y_ff) + ((DELAY_W+1)'(1) << ROUND_BIT);
      r_q     = y_rnd[DELAY_W:FRAC_W];
      r_upper = r_q[DELAY_W-FRAC_W:SAMPLE_W-1];
      if ((&r_upper) || !(|r_upper)) begin
         res_sample = r_q[SAMPLE_W-1:0];
         res_clip   = 1'b0;
      end else begin
         res_sample = r_q[DELAY_W-FRAC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_W-1){1'b1}}};
         res_clip   = 1'b1;
      end
   end

   // Output register with one skid entry behind it
   assign rsp_open = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_clip_in    = rsp_clip_ff;
      pend_valid_in  = pend_valid_ff;
      pend_sample_in = pend_sample_ff;
      pend_clip_in   = pend_clip_ff;
      if (pend_valid_ff && rsp_open) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = pend_sample_ff;
         rsp_clip_in   = pend_clip_ff;
         pend_valid_in = 1'b0;
      end else if (emit_ff) begin
         if (rsp_open) begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = res_sample;
            rsp_clip_in   = res_clip;
         end else begin
            pend_valid_in  = 1'b1;
            pend_sample_in = res_sample;
            pend_clip_in   = res_clip;
         end
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         emit_ff       <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         emit_ff       <= uc.emit;
      end
      rsp_sample_ff  <= rsp_sample_in;
      rsp_clip_ff    <= rsp_clip_in;
      pend_sample_ff <= pend_sample_in;
      pend_clip_ff   <= pend_clip_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.clipped    = rsp_clip_ff;

   // Checks
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds an item while the output register is empty");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> !pend_valid_ff)
      else $error("result produced while the skid entry is full");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == ST_Y))
      else $error("accepted item did not start the program");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff != ST_IDLE) |-> ((t_ff >= TAP_W'(1)) && (t_ff <= LAST_TAP)))
      else $error("tap counter out of range inside the program");

endmodule
